/* rtl/core/msp_pkg.sv */
// Package: widths, codes and controller/datapath types for the segment planner.
package msp_pkg;

  // Field widths of the input and result words
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned CAP_W   = 14;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned AVAIL_W = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned SIZE_W  = 14;

  // Shared divider operand width and planned count width
  localparam int unsigned DIV_W   = LEN_W;
  localparam int unsigned PLAN_W  = DIV_W + 1;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_PACKETS       = 64;
  localparam int unsigned DEF_MAX_MESSAGE_BYTES = 65536;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RETRY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ERROR = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_CNT,
    ST_START_SIZE,
    ST_DIV_SIZE,
    ST_START_FULL,
    ST_DIV_FULL,
    ST_PLAN,
    ST_EMIT,
    ST_RETRY,
    ST_ERROR
  } msp_state_e;

  // Which division the shared divider runs
  typedef enum logic [1:0] {
    DIV_CNT,
    DIV_SIZE,
    DIV_FULL
  } msp_div_sel_e;

  // Kind of result word pushed to the output register
  typedef enum logic [1:0] {
    PUSH_OK,
    PUSH_RETRY,
    PUSH_ERR
  } msp_push_e;

  // Controller to datapath commands
  typedef struct packed {
    logic         load;
    logic         div_start;
    msp_div_sel_e div_sel;
    logic         cap_min;
    logic         cap_size;
    logic         cap_full;
    logic         push;
    msp_push_e    push_kind;
  } msp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad_req;
    logic div_done;
    logic size_zero;
    logic retry;
    logic out_free;
    logic last_pkt;
  } msp_sts_t;

endpackage

/* rtl/core/msp_in_if.sv */
// Interface: request word channel (message length, capacity, alignment, free packets).
interface msp_in_if
  import msp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   message_length;
  logic [CAP_W-1:0]   max_payload;
  logic [SHIFT_W-1:0] align_shift;
  logic [AVAIL_W-1:0] free_packets;

  modport source (
    output valid, message_length, max_payload, align_shift, free_packets,
    input  ready
  );

  modport sink (
    input  valid, message_length, max_payload, align_shift, free_packets,
    output ready
  );
endinterface

/* rtl/core/msp_out_if.sv */
// Interface: result word channel (one word per planned packet or one status word).
interface msp_out_if
  import msp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  packet_count;
  logic [IDX_W-1:0]  packet_index;
  logic [OFS_W-1:0]  data_offset;
  logic [SIZE_W-1:0] segment_size;
  logic              last;

  modport source (
    output valid, status, packet_count, packet_index, data_offset, segment_size, last,
    input  ready
  );

  modport sink (
    input  valid, status, packet_count, packet_index, data_offset, segment_size, last,
    output ready
  );
endinterface

/* rtl/core/message_segment_planner.sv */
// Top level: message segment planner, controller plus datapath with a shared divider.
//
//   channel | dir | word contents
//   --------+-----+---------------------------------------------------------------
//   in_i    | in  | message_length, max_payload, align_shift, free_packets
//   out_o   | out | status, packet_count, packet_index, data_offset, segment_size, last
//
// After a request is accepted, planning runs a check state, three divisions on one
// shared divider (17 restoring steps each, then the done flag), two divider start
// states and a plan state; then one result word per cycle while out_o is ready.
// A malformed request gets an error word from the check state, with no division.
// A new request is taken once the last word of the previous one sits in the output
// register. Reset clears the controller, divider control and output valid only.
// Stalls on out_o hold the output word and pause emission; nothing is dropped.
module message_segment_planner
  import msp_pkg::*;
#(
  parameter int unsigned MAX_PACKETS       = DEF_MAX_PACKETS,
  parameter int unsigned MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msp_in_if.sink    in_i,
  msp_out_if.source out_o
);

  msp_cmd_t cmd;
  msp_sts_t sts;

  msp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msp_dp #(
    .MAX_PACKETS       (MAX_PACKETS),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .message_length_i (in_i.message_length),
    .max_payload_i    (in_i.max_payload),
    .align_shift_i    (in_i.align_shift),
    .free_packets_i   (in_i.free_packets),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .status_o         (out_o.status),
    .packet_count_o   (out_o.packet_count),
    .packet_index_o   (out_o.packet_index),
    .data_offset_o    (out_o.data_offset),
    .segment_size_o   (out_o.segment_size),
    .last_o           (out_o.last)
  );

endmodule

/* rtl/core/msp_div.sv */
// Shared restoring divider: one quotient bit per cycle.
module msp_div
  import msp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o,
  output logic [DIV_W-1:0] remainder_o
);

  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // One restoring step
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    quo_d = {quo_q[DIV_W-2:0], ge};
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(DIV_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/core/msp_dp.sv */
// Datapath: request registers, plan registers, shared divider and output word register.
module msp_dp
  import msp_pkg::*;
#(
  parameter int unsigned MAX_PACKETS       = DEF_MAX_PACKETS,
  parameter int unsigned MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msp_cmd_t           cmd_i,
  output msp_sts_t           sts_o,
  input  logic [LEN_W-1:0]   message_length_i,
  input  logic [CAP_W-1:0]   max_payload_i,
  input  logic [SHIFT_W-1:0] align_shift_i,
  input  logic [AVAIL_W-1:0] free_packets_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [CNT_W-1:0]   packet_count_o,
  output logic [IDX_W-1:0]   packet_index_o,
  output logic [OFS_W-1:0]   data_offset_o,
  output logic [SIZE_W-1:0]  segment_size_o,
  output logic               last_o
);

  localparam int unsigned MSG_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int unsigned CMP_W = (MSG_W > LEN_W) ? MSG_W : LEN_W;

  // Request registers
  logic [LEN_W-1:0]   len_q;
  logic [CAP_W-1:0]   cap_q;
  logic [SHIFT_W-1:0] shift_q;
  logic [AVAIL_W-1:0] avail_q;

  // Plan registers
  logic [DIV_W-1:0]   mcnt_q;
  logic [SIZE_W-1:0]  size_q;
  logic [SIZE_W-1:0]  rem_q;
  logic               ex_q;
  logic [PLAN_W-1:0]  count_q;
  logic [IDX_W-1:0]   idx_q;
  logic [OFS_W-1:0]   ofs_q;

  // Output word register
  logic               out_valid_q;
  logic [STAT_W-1:0]  stat_q;
  logic [CNT_W-1:0]   ocnt_q;
  logic [IDX_W-1:0]   oidx_q;
  logic [OFS_W-1:0]   oofs_q;
  logic [SIZE_W-1:0]  osize_q;
  logic               olast_q;

  // Divider hookup
  logic [DIV_W-1:0]   dividend;
  logic [DIV_W-1:0]   divisor;
  logic               div_done;
  logic [DIV_W-1:0]   quo;
  logic [DIV_W-1:0]   rem;

  logic [SIZE_W-1:0]  size_raw;
  logic [SIZE_W-1:0]  align_mask;
  logic               extra;
  logic [AVAIL_W-1:0] limit;
  logic               last_pkt;
  logic [SIZE_W-1:0]  this_size;
  logic [CNT_W-1:0]   sat_count;

  msp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // Divider operand select
  always_comb begin
    case (cmd_i.div_sel)
      DIV_CNT: begin
        dividend = len_q - LEN_W'(1);
        divisor  = DIV_W'(cap_q);
      end
      DIV_SIZE: begin
        dividend = len_q - LEN_W'(1);
        divisor  = mcnt_q;
      end
      DIV_FULL: begin
        dividend = len_q;
        divisor  = DIV_W'(size_q);
      end
      default: begin
        dividend = len_q;
        divisor  = DIV_W'(cap_q);
      end
    endcase
  end

  // Ceiling division result rounded down to the alignment; extra packet check for the remainder
  always_comb begin
    size_raw   = SIZE_W'(quo + DIV_W'(1));
    align_mask = ~((SIZE_W'(1) << shift_q) - SIZE_W'(1));
    extra      = ({1'b0, size_q} + {1'b0, rem[SIZE_W-1:0]}) > {1'b0, cap_q};
  end

  // Emission helpers
  always_comb begin
    limit     = (avail_q < AVAIL_W'(MAX_PACKETS)) ? avail_q : AVAIL_W'(MAX_PACKETS);
    last_pkt  = ({1'b0, idx_q} + CNT_W'(1)) == count_q[CNT_W-1:0];
    if (!last_pkt) begin
      this_size = size_q;
    end else if (ex_q) begin
      this_size = rem_q;
    end else begin
      this_size = size_q + rem_q;
    end
    sat_count = (count_q > PLAN_W'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} : count_q[CNT_W-1:0];
  end

  // Status to the controller
  always_comb begin
    sts_o.bad_req   = (len_q == '0) || (cap_q == '0) ||
                      (CMP_W'(len_q) > CMP_W'(MAX_MESSAGE_BYTES));
    sts_o.div_done  = div_done;
    sts_o.size_zero = (size_q == '0);
    sts_o.retry     = count_q > PLAN_W'(limit);
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.last_pkt  = last_pkt;
  end

  // Request and plan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q   <= message_length_i;
      cap_q   <= max_payload_i;
      shift_q <= align_shift_i;
      avail_q <= free_packets_i;
    end
    if (cmd_i.cap_min) begin
      mcnt_q <= quo + DIV_W'(1);
    end
    if (cmd_i.cap_size) begin
      size_q <= size_raw & align_mask;
    end
    if (cmd_i.cap_full) begin
      rem_q   <= rem[SIZE_W-1:0];
      ex_q    <= extra;
      count_q <= {1'b0, quo} + PLAN_W'(extra);
      idx_q   <= '0;
      ofs_q   <= '0;
    end else if (cmd_i.push && (cmd_i.push_kind == PUSH_OK)) begin
      idx_q <= idx_q + IDX_W'(1);
      ofs_q <= ofs_q + OFS_W'(this_size);
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      case (cmd_i.push_kind)
        PUSH_OK: begin
          stat_q  <= STAT_OK;
          ocnt_q  <= count_q[CNT_W-1:0];
          oidx_q  <= idx_q;
          oofs_q  <= ofs_q;
          osize_q <= this_size;
          olast_q <= last_pkt;
        end
        PUSH_RETRY: begin
          stat_q  <= STAT_RETRY;
          ocnt_q  <= sat_count;
          oidx_q  <= '0;
          oofs_q  <= '0;
          osize_q <= '0;
          olast_q <= 1'b1;
        end
        default: begin
          stat_q  <= STAT_ERROR;
          ocnt_q  <= '0;
          oidx_q  <= '0;
          oofs_q  <= '0;
          osize_q <= '0;
          olast_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = stat_q;
  assign packet_count_o = ocnt_q;
  assign packet_index_o = oidx_q;
  assign data_offset_o  = oofs_q;
  assign segment_size_o = osize_q;
  assign last_o         = olast_q;

endmodule

/* rtl/core/msp_ctrl.sv */
// Controller: sequences the three divisions, the plan checks and word emission.
module msp_ctrl
  import msp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  msp_sts_t sts_i,
  output msp_cmd_t cmd_o
);

  msp_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.bad_req ? ST_ERROR : ST_DIV_CNT;
      end
      ST_DIV_CNT: begin
        if (sts_i.div_done) state_d = ST_START_SIZE;
      end
      ST_START_SIZE: begin
        state_d = ST_DIV_SIZE;
      end
      ST_DIV_SIZE: begin
        if (sts_i.div_done) state_d = ST_START_FULL;
      end
      ST_START_FULL: begin
        state_d = sts_i.size_zero ? ST_ERROR : ST_DIV_FULL;
      end
      ST_DIV_FULL: begin
        if (sts_i.div_done) state_d = ST_PLAN;
      end
      ST_PLAN: begin
        state_d = sts_i.retry ? ST_RETRY : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.last_pkt) state_d = ST_IDLE;
      end
      ST_RETRY, ST_ERROR: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.div_sel   = DIV_CNT;
    cmd_o.push_kind = PUSH_OK;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.div_start = !sts_i.bad_req;
        cmd_o.div_sel   = DIV_CNT;
      end
      ST_DIV_CNT: begin
        cmd_o.cap_min = sts_i.div_done;
      end
      ST_START_SIZE: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SIZE;
      end
      ST_DIV_SIZE: begin
        cmd_o.cap_size = sts_i.div_done;
      end
      ST_START_FULL: begin
        cmd_o.div_start = !sts_i.size_zero;
        cmd_o.div_sel   = DIV_FULL;
      end
      ST_DIV_FULL: begin
        cmd_o.cap_full = sts_i.div_done;
      end
      ST_EMIT: begin
        cmd_o.push      = sts_i.out_free;
        cmd_o.push_kind = PUSH_OK;
      end
      ST_RETRY: begin
        cmd_o.push      = sts_i.out_free;
        cmd_o.push_kind = PUSH_RETRY;
      end
      ST_ERROR: begin
        cmd_o.push      = sts_i.out_free;
        cmd_o.push_kind = PUSH_ERR;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* sim/message_segment_planner_tb.sv */
// Testbench for the message segment planner: directed table, random requests, segment scoreboard.
`timescale 1ns / 100ps

module message_segment_planner_tb;
  import msp_pkg::*;

  localparam int unsigned MAX_PKTS       = DEF_MAX_PACKETS;
  localparam int unsigned MAX_MSG        = DEF_MAX_MESSAGE_BYTES;
  localparam int unsigned NUM_ROWS       = 22;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  // One request word as driven on in_i
  typedef struct packed {
    logic [LEN_W-1:0]   message_length;
    logic [CAP_W-1:0]   max_payload;
    logic [SHIFT_W-1:0] align_shift;
    logic [AVAIL_W-1:0] free_packets;
  } msg_req_t;

  // One planned result word as seen on out_o
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  packet_count;
    logic [IDX_W-1:0]  packet_index;
    logic [OFS_W-1:0]  data_offset;
    logic [SIZE_W-1:0] segment_size;
    logic              last;
  } seg_word_t;

  // Directed row; typed rows carry a single result word (index 0, offset 0, last set)
  typedef struct {
    int unsigned       len;
    int unsigned       cap;
    int unsigned       shift;
    int unsigned       avail;
    bit                typed;
    logic [STAT_W-1:0] status;
    int unsigned       count;
    int unsigned       size;
  } directed_row_t;

  logic clk;
  logic rst_ni;

  msp_in_if  in_ch ();
  msp_out_if out_ch ();

  message_segment_planner #(
    .MAX_PACKETS      (MAX_PKTS),
    .MAX_MESSAGE_BYTES(MAX_MSG)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  seg_word_t   planned_segments [$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned ok_words;
  int unsigned retry_words;
  int unsigned error_words;
  int unsigned holds_done;
  int unsigned hold_left;
  bit          hold_req;
  int unsigned src_idle;    // percent chance that the sender's idle gap after a request keeps growing
  int unsigned snk_idle;    // percent of cycles the receiver stalls
  seg_word_t   due;
  seg_word_t   seen;

  directed_row_t directed_rows [NUM_ROWS] = '{
    '{0,      100,   0,  10,  1'b1, STAT_ERROR, 0,   0},  // zero length
    '{100,    0,     0,  10,  1'b1, STAT_ERROR, 0,   0},  // zero capacity
    '{65537,  4096,  0,  64,  1'b1, STAT_ERROR, 0,   0},  // one byte over the maximum
    '{131071, 16383, 15, 127, 1'b1, STAT_ERROR, 0,   0},  // all fields all ones
    '{1,      1,     0,  1,   1'b1, STAT_OK,    1,   1},  // smallest message
    '{100,    16383, 12, 1,   1'b1, STAT_ERROR, 0,   0},  // alignment rounds size to zero
    '{65536,  16383, 15, 64,  1'b1, STAT_ERROR, 0,   0},
    '{65536,  16383, 14, 64,  1'b1, STAT_ERROR, 0,   0},
    '{65536,  16383, 13, 64,  1'b0, STAT_OK,    0,   0},
    '{65536,  16383, 0,  127, 1'b0, STAT_OK,    0,   0},  // largest message, largest capacity
    '{65536,  1,     0,  127, 1'b1, STAT_RETRY, 127, 0},  // retry count saturates
    '{1000,   100,   0,  0,   1'b1, STAT_RETRY, 10,  0},  // no free packets
    '{1000,   100,   0,  9,   1'b1, STAT_RETRY, 10,  0},  // one short
    '{1000,   100,   0,  10,  1'b0, STAT_OK,    0,   0},  // exactly enough
    '{1000,   300,   3,  20,  1'b0, STAT_OK,    0,   0},  // remainder joins last packet
    '{1000,   250,   4,  20,  1'b0, STAT_OK,    0,   0},  // remainder needs extra packet
    '{65536,  1024,  0,  64,  1'b0, STAT_OK,    0,   0},  // full 64 packet plan
    '{65536,  1024,  0,  63,  1'b1, STAT_RETRY, 64,  0},
    '{65536,  1024,  0,  127, 1'b0, STAT_OK,    0,   0},  // free count above packet pool
    '{43690,  10922, 5,  85,  1'b0, STAT_OK,    0,   0},  // alternating bits
    '{87381,  5461,  10, 42,  1'b1, STAT_ERROR, 0,   0},
    '{5461,   10922, 10, 42,  1'b0, STAT_OK,    0,   0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Queue one planned result word, count saturated to its field
  function automatic void add_segment(input logic [STAT_W-1:0] st, input int unsigned cnt,
                                      input int unsigned idx, input int unsigned ofs,
                                      input int unsigned sz, input bit fin);
    seg_word_t w;
    w.status       = st;
    w.packet_count = CNT_W'((cnt > 127) ? 127 : cnt);
    w.packet_index = IDX_W'(idx);
    w.data_offset  = OFS_W'(ofs);
    w.segment_size = SIZE_W'(sz);
    w.last         = fin;
    planned_segments.push_back(w);
  endfunction

  // Segment plan for one request: error or retry word, or even split, aligned base size, remainder placement
  function automatic void plan_segments(input msg_req_t r);
    int unsigned len, cap, shift, avail;
    int unsigned min_cnt, size, full, rem, count, limit, offset, this_size, i;
    len   = 32'(r.message_length);
    cap   = 32'(r.max_payload);
    shift = 32'(r.align_shift);
    avail = 32'(r.free_packets);
    if (len == 0 || cap == 0 || len > MAX_MSG) begin
      add_segment(STAT_ERROR, 0, 0, 0, 0, 1'b1);
      return;
    end
    min_cnt = (len - 1) / cap + 1;
    size    = (len - 1) / min_cnt + 1;
    size    = size & ~((32'd1 << shift) - 32'd1);
    if (size == 0) begin
      add_segment(STAT_ERROR, 0, 0, 0, 0, 1'b1);
      return;
    end
    full  = len / size;
    rem   = len - full * size;
    count = full + ((size + rem > cap) ? 1 : 0);
    limit = (avail < MAX_PKTS) ? avail : MAX_PKTS;
    if (count > limit) begin
      add_segment(STAT_RETRY, count, 0, 0, 0, 1'b1);
      return;
    end
    offset = 0;
    for (i = 0; i < count; i++) begin
      this_size = size;
      if (count == full) begin
        if (i == full - 1) this_size = size + rem;
      end else if (i == full) begin
        this_size = rem;
      end
      add_segment(STAT_OK, count, i, offset, this_size, (i + 1 == count));
      offset += this_size;
    end
  endfunction

  // Random request: mostly plannable messages, some short on packets, some raw noise
  function automatic msg_req_t draw_request();
    msg_req_t    r;
    int unsigned pick, len, parts, cap;
    pick = $urandom_range(99);
    if (pick >= 90) begin
      r.message_length = LEN_W'($urandom);
      r.max_payload    = CAP_W'($urandom);
      r.align_shift    = SHIFT_W'($urandom);
      r.free_packets   = AVAIL_W'($urandom);
      return r;
    end
    len   = ($urandom_range(9) < 8) ? $urandom_range(1, 4096) : $urandom_range(1, MAX_MSG);
    parts = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 64);
    cap   = (len + parts - 1) / parts + $urandom_range(0, 7);
    if (cap > 16383) cap = 16383;
    r.message_length = LEN_W'(len);
    r.max_payload    = CAP_W'(cap);
    r.align_shift    = SHIFT_W'(($urandom_range(9) < 8) ? $urandom_range(0, 3)
                                                        : $urandom_range(4, 15));
    // retry-leaning requests get no more free packets than the intended number of parts
    r.free_packets   = AVAIL_W'((pick >= 75) ? $urandom_range(0, parts)
                                             : $urandom_range(parts + 1, 127));
    return r;
  endfunction

  // Drive one request word, hold until accepted, then maybe idle
  task automatic send_request(input msg_req_t r);
    int unsigned gap;
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.message_length <= r.message_length;
    in_ch.max_payload    <= r.max_payload;
    in_ch.align_shift    <= r.align_shift;
    in_ch.free_packets   <= r.free_packets;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
    gap = 0;
    if (src_idle > 0) begin
      while (gap < 24 && $urandom_range(99) < src_idle) gap++;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic run_random_phase(input int unsigned n, input int unsigned src,
                                  input int unsigned snk);
    msg_req_t r;
    src_idle = src;
    snk_idle = snk;
    repeat (n) begin
      r = draw_request();
      plan_segments(r);
      send_request(r);
    end
  endtask

  // Wait until every planned word has come out, then let the block settle
  task automatic drain_results();
    while (planned_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: reset, directed table, then random phases
  initial begin
    msg_req_t r;
    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.message_length = '0;
    in_ch.max_payload    = '0;
    in_ch.align_shift    = '0;
    in_ch.free_packets   = '0;
    src_idle             = 0;
    snk_idle             = 0;
    hold_req             = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) begin
      r.message_length = LEN_W'(directed_rows[k].len);
      r.max_payload    = CAP_W'(directed_rows[k].cap);
      r.align_shift    = SHIFT_W'(directed_rows[k].shift);
      r.free_packets   = AVAIL_W'(directed_rows[k].avail);
      if (directed_rows[k].typed) begin
        add_segment(directed_rows[k].status, directed_rows[k].count, 0, 0,
                    directed_rows[k].size, 1'b1);
      end else begin
        plan_segments(r);
      end
      send_request(r);
    end

    // sender pauses until the block is empty
    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain_results();

    run_random_phase(80, 0, 0);
    run_random_phase(110, 54, 0);
    // long receiver hold while requests keep coming, block backs up
    @(posedge clk);
    hold_req = 1'b1;
    run_random_phase(40, 0, 0);
    run_random_phase(110, 0, 54);
    run_random_phase(110, 23, 23);
    run_random_phase(20, 0, 0);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain_results();

    $display("run: %0d requests, %0d ok / %0d retry / %0d error words checked",
             requests_sent, ok_words, retry_words, error_words);
    $display("run: idle and stall phases, %0d long receiver hold(s), %0d mismatch(es)",
             holds_done, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: ready per phase, plus a long counted hold on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    holds_done   = 0;
    @(posedge rst_ni);
    forever @(negedge clk) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (snk_idle > 0) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check every accepted result word against the oldest planned one
  always @(posedge clk) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen.status       = out_ch.status;
      seen.packet_count = out_ch.packet_count;
      seen.packet_index = out_ch.packet_index;
      seen.data_offset  = out_ch.data_offset;
      seen.segment_size = out_ch.segment_size;
      seen.last         = out_ch.last;
      if (seen.status == STAT_OK) ok_words++;
      else if (seen.status == STAT_RETRY) retry_words++;
      else error_words++;
      if (planned_segments.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unplanned word st=%0d cnt=%0d idx=%0d ofs=%0d sz=%0d last=%0d",
                   $realtime, seen.status, seen.packet_count, seen.packet_index,
                   seen.data_offset, seen.segment_size, seen.last);
      end else begin
        due = planned_segments.pop_front();
        if (seen.status !== due.status || seen.packet_count !== due.packet_count ||
            seen.packet_index !== due.packet_index ||
            seen.data_offset !== due.data_offset ||
            seen.segment_size !== due.segment_size || seen.last !== due.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: word differs, exp st=%0d cnt=%0d idx=%0d ofs=%0d sz=%0d last=%0d",
                     $realtime, due.status, due.packet_count, due.packet_index,
                     due.data_offset, due.segment_size, due.last);
            $display("%0t:               got st=%0d cnt=%0d idx=%0d ofs=%0d sz=%0d last=%0d",
                     $realtime, seen.status, seen.packet_count, seen.packet_index,
                     seen.data_offset, seen.segment_size, seen.last);
          end
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a word, %0d result word(s) outstanding",
             quiet, planned_segments.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/msp_pkg.sv
rtl/core/msp_in_if.sv
rtl/core/msp_out_if.sv
rtl/core/msp_div.sv
rtl/core/msp_dp.sv
rtl/core/msp_ctrl.sv
rtl/core/message_segment_planner.sv
sim/message_segment_planner_tb.sv
